[src/mfq_pkg.sv]
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

  localparam int SLOT_COUNT_DEF  = 16;
  localparam int LEVEL_COUNT_DEF = 4;

  localparam int QW = 30;   // quantum, burst and io wait width
  localparam int TW = 48;   // time width

  localparam logic [QW-1:0] QUANTUM0_RST = 30'd10000;
  localparam logic [QW-1:0] QUANTUM1_RST = 30'd20000;
  localparam logic [QW-1:0] QUANTUM2_RST = 30'd40000;
  localparam logic [QW-1:0] QUANTUM3_RST = 30'd60000;

  // operation codes
  localparam logic [1:0] OP_ADMIT    = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_OUTCOME  = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  // run outcome codes
  localparam logic [1:0] OC_READY   = 2'd0;
  localparam logic [1:0] OC_BLOCKED = 2'd1;
  localparam logic [1:0] OC_EXITED  = 2'd2;
  localparam logic [1:0] OC_NONE    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IDLE    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NO_DISP = 2'd3;

  typedef struct packed {
    logic [1:0]    op;
    logic [7:0]    proc_id;
    logic [TW-1:0] now;
    logic [1:0]    outcome;
    logic [QW-1:0] burst;
    logic [QW-1:0] io_wait;
  } in_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [3:0]    slot;
    logic [7:0]    out_proc_id;
    logic [1:0]    level;
    logic [QW-1:0] granted_quantum;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic read_a;
    logic read_b;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

[src/multilevel_feedback_queue_scheduler.sv]
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Multilevel feedback queue scheduler over a table of process slots.
// ----------------------------------------------------------------------------
// Each op word (admit, dispatch, run outcome, tick) yields exactly one result
// word. An op holds the block from acceptance through commit. The accepting
// edge latches the word. The read-A step reads the head of the ready or
// blocked queue RAM, the read-B step reads the slot's process id and wake
// time, and the commit step updates the queues and loads the result register.
// These chained registered RAM reads set the length of the sequence. The next
// word can be accepted at the edge after commit, so no new word is taken
// before the previous one has committed, but one is taken as soon as it has,
// even while its result still waits; commit stalls only while the result
// register is still full. Quanta may be written at any idle time.
module multilevel_feedback_queue_scheduler #(
  parameter int SLOT_COUNT  = mfq_pkg::SLOT_COUNT_DEF,
  parameter int LEVEL_COUNT = mfq_pkg::LEVEL_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mfq_pkg::in_t           in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mfq_pkg::out_t          out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [mfq_pkg::QW-1:0] cfg_data
);
  import mfq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfq_dp #(.SLOT_COUNT(SLOT_COUNT), .LEVEL_COUNT(LEVEL_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

`ifndef SYNTH
  // one word in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while another is in flight");

  // commit always presents a result
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without result");

  // sequencer steps are exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.read_a, cmd.read_b, cmd.commit}))
    else $error("overlapping sequencer commands");
`endif

endmodule

[src/mfq_ram.sv]
// ----------------------------------------------------------------------------
// mfq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/mfq_ctrl.sv]
// ----------------------------------------------------------------------------
// mfq_ctrl
// Sequencer: accept a word, read queue store, read slot tables, commit.
// ----------------------------------------------------------------------------
module mfq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfq_pkg::sts_t sts,
  output mfq_pkg::cmd_t cmd
);
  import mfq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RDA  = 2'd1;
  localparam logic [1:0] S_RDB  = 2'd2;
  localparam logic [1:0] S_COMM = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.load    = in_valid && (state == S_IDLE);
  assign cmd.read_a  = (state == S_RDA);
  assign cmd.read_b  = (state == S_RDB);
  assign cmd.commit  = (state == S_COMM) && !sts.out_busy;

  // advance through the steps, hold in commit while the output is full
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.load) state_next = S_RDA;
      S_RDA:  state_next = S_RDB;
      S_RDB:  state_next = S_COMM;
      S_COMM: if (cmd.commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/mfq_dp.sv]
// ----------------------------------------------------------------------------
// mfq_dp
// Scheduler datapath: slot map, queue pointers, queue and slot RAMs, result.
// ----------------------------------------------------------------------------
module mfq_dp #(
  parameter int SLOT_COUNT  = mfq_pkg::SLOT_COUNT_DEF,
  parameter int LEVEL_COUNT = mfq_pkg::LEVEL_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mfq_pkg::in_t            in_data,
  input  mfq_pkg::cmd_t           cmd,
  output mfq_pkg::sts_t           sts,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mfq_pkg::out_t           out_data,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [mfq_pkg::QW-1:0]  cfg_data
);
  import mfq_pkg::*;

  localparam int HW  = $clog2(SLOT_COUNT);
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int PW  = CW + 1;
  localparam int LW  = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int RQD = LEVEL_COUNT * SLOT_COUNT;
  localparam int RAW = $clog2(RQD);
  localparam logic [CW-1:0] CNT_FULL = CW'(SLOT_COUNT);

  // registers
  in_t              in_q;
  logic [SLOT_COUNT-1:0] used;
  logic [CW-1:0]    cnt [LEVEL_COUNT];
  logic [HW-1:0]    head [LEVEL_COUNT];
  logic [HW-1:0]    blk_head;
  logic [CW-1:0]    blk_cnt;
  logic [LW-1:0]    dl;
  logic             pending;
  logic [QW-1:0]    quantum [4];
  logic [HW-1:0]    s_q;

  // RAM ports
  logic             rq_we, rq_re;
  logic [RAW-1:0]   rq_waddr, rq_raddr;
  logic [HW-1:0]    rq_rdata;
  logic             bq_we;
  logic [HW-1:0]    bq_waddr;
  logic [HW-1:0]    bq_rdata;
  logic             pid_we;
  logic [7:0]       pid_rdata;
  logic             wk_we;
  logic [TW-1:0]    wk_wdata, wk_rdata;

  // combinational helpers
  logic             any_free;
  logic [HW-1:0]    free_s;
  logic             any_ready;
  logic [LW-1:0]    lvl_sel;
  logic [LW-1:0]    rd_lvl;
  logic [HW-1:0]    s_b;
  logic             oc_ok;
  logic [LW-1:0]    nl;
  logic [LW-1:0]    push_lvl;
  logic             push_ok;
  logic [HW-1:0]    push_pos;
  logic [HW-1:0]    blk_tail;
  logic             tick_ok;
  logic [TW+1:0]    wake_sum;
  logic [HW-1:0]    head_dl_inc;
  out_t             res;

  // wrap (a + b) into the slot range, a and b below the slot count plus one
  function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] a, input logic [CW-1:0] b);
    logic [PW-1:0] sum;
    sum = PW'(a) + PW'(b);
    if (sum >= PW'(SLOT_COUNT)) begin
      sum = sum - PW'(SLOT_COUNT);
    end
    return HW'(sum);
  endfunction

  function automatic logic [RAW-1:0] rq_addr(input logic [LW-1:0] l, input logic [HW-1:0] p);
    return RAW'(32'(l) * SLOT_COUNT + 32'(p));
  endfunction

  function automatic logic [QW-1:0] quantum_of(input logic [LW-1:0] l,
                                               input logic [QW-1:0] q0,
                                               input logic [QW-1:0] q1,
                                               input logic [QW-1:0] q2,
                                               input logic [QW-1:0] q3);
    logic [QW-1:0] q;
    case (32'(l))
      0: q = q0;
      1: q = q1;
      2: q = q2;
      default: q = q3;
    endcase
    return q;
  endfunction

  // lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_s   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        any_free = 1'b1;
        free_s   = HW'(i);
      end
    end
  end

  // highest priority non-empty level
  always_comb begin
    any_ready = 1'b0;
    lvl_sel   = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (cnt[i] != '0) begin
        any_ready = 1'b1;
        lvl_sel   = LW'(i);
      end
    end
  end

  // first read: queue heads
  assign rd_lvl   = (in_q.op == OP_DISPATCH) ? lvl_sel : dl;
  assign rq_re    = cmd.read_a;
  assign rq_raddr = rq_addr(rd_lvl, head[rd_lvl]);

  // second read: slot tables at the slot just read
  assign s_b = (in_q.op == OP_TICK) ? bq_rdata : rq_rdata;

  // decisions taken at commit
  assign oc_ok   = pending && (cnt[dl] != '0) && (in_q.outcome != OC_NONE);
  assign tick_ok = (blk_cnt != '0) && !(wk_rdata > in_q.now);

  always_comb begin
    nl = dl;
    if ((in_q.burst >= quantum_of(dl, quantum[0], quantum[1], quantum[2], quantum[3]))
        && (32'(dl) + 1 < LEVEL_COUNT)) begin
      nl = LW'(32'(dl) + 1);
    end
  end

  assign push_lvl = (in_q.op == OP_OUTCOME) ? nl : '0;
  // popping and pushing the same level leaves the tail where it was
  assign push_pos = wrap_add(head[push_lvl], cnt[push_lvl]);
  assign push_ok  = (push_lvl == dl && in_q.op == OP_OUTCOME) ? 1'b1
                                                              : (cnt[push_lvl] < CNT_FULL);
  assign head_dl_inc = (32'(head[dl]) == SLOT_COUNT - 1) ? '0 : head[dl] + 1'b1;
  assign blk_tail    = wrap_add(blk_head, blk_cnt);

  // saturating wake time
  assign wake_sum = (TW+2)'(in_q.now) + (TW+2)'(in_q.io_wait) + (TW+2)'(in_q.burst);
  assign wk_wdata = (wake_sum > (TW+2)'({TW{1'b1}})) ? {TW{1'b1}} : TW'(wake_sum);

  // RAM writes at commit
  always_comb begin
    rq_we    = 1'b0;
    bq_we    = 1'b0;
    pid_we   = 1'b0;
    wk_we    = 1'b0;
    rq_waddr = rq_addr(push_lvl, push_pos);
    bq_waddr = blk_tail;
    if (cmd.commit) begin
      case (in_q.op)
        OP_ADMIT: begin
          pid_we = any_free;
          rq_we  = any_free && push_ok;
        end
        OP_OUTCOME: begin
          rq_we = oc_ok && (in_q.outcome == OC_READY) && push_ok;
          wk_we = oc_ok && (in_q.outcome == OC_BLOCKED);
          bq_we = oc_ok && (in_q.outcome == OC_BLOCKED) && (blk_cnt < CNT_FULL);
        end
        OP_TICK: begin
          rq_we = tick_ok && push_ok;
        end
        default: begin
          rq_we = 1'b0;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res = '0;
    case (in_q.op)
      OP_ADMIT: begin
        if (any_free) begin
          res.status      = ST_DONE;
          res.slot        = 4'(free_s);
          res.out_proc_id = in_q.proc_id;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_DISPATCH: begin
        if (any_ready) begin
          res.status          = ST_DONE;
          res.slot            = 4'(s_q);
          res.out_proc_id     = pid_rdata;
          res.level           = 2'(lvl_sel);
          res.granted_quantum = quantum_of(lvl_sel, quantum[0], quantum[1],
                                           quantum[2], quantum[3]);
        end else begin
          res.status = ST_IDLE;
        end
      end
      OP_OUTCOME: begin
        if (!pending || cnt[dl] == '0) begin
          res.status = ST_NO_DISP;
        end else if (in_q.outcome == OC_NONE) begin
          res.status = ST_IDLE;
        end else begin
          res.status      = ST_DONE;
          res.slot        = 4'(s_q);
          res.out_proc_id = pid_rdata;
          res.level       = (in_q.outcome == OC_READY) ? 2'(nl) : 2'(dl);
        end
      end
      default: begin
        if (tick_ok) begin
          res.status      = ST_DONE;
          res.slot        = 4'(s_q);
          res.out_proc_id = pid_rdata;
        end else begin
          res.status = ST_IDLE;
        end
      end
    endcase
  end

  assign sts.out_busy = out_valid && !out_ready;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q <= in_data;
    end
    if (cmd.read_b) begin
      s_q <= s_b;
    end
    if (cmd.commit) begin
      out_data <= res;
    end
  end

  // control state: slot map, queue pointers, dispatch record, quanta
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      blk_head  <= '0;
      blk_cnt   <= '0;
      dl        <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      quantum[0] <= QUANTUM0_RST;
      quantum[1] <= QUANTUM1_RST;
      quantum[2] <= QUANTUM2_RST;
      quantum[3] <= QUANTUM3_RST;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        cnt[i]  <= '0;
        head[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        quantum[cfg_index] <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        case (in_q.op)
          OP_ADMIT: begin
            if (any_free) begin
              used[free_s] <= 1'b1;
              if (push_ok) begin
                cnt[0] <= cnt[0] + 1'b1;
              end
            end
          end
          OP_DISPATCH: begin
            if (any_ready) begin
              pending <= 1'b1;
              dl      <= lvl_sel;
            end
          end
          OP_OUTCOME: begin
            if (oc_ok) begin
              pending  <= 1'b0;
              head[dl] <= head_dl_inc;
              if (in_q.outcome == OC_READY) begin
                if (nl != dl) begin
                  cnt[dl] <= cnt[dl] - 1'b1;
                  if (push_ok) begin
                    cnt[nl] <= cnt[nl] + 1'b1;
                  end
                end
              end else begin
                cnt[dl] <= cnt[dl] - 1'b1;
                if (in_q.outcome == OC_BLOCKED) begin
                  if (blk_cnt < CNT_FULL) begin
                    blk_cnt <= blk_cnt + 1'b1;
                  end
                end else begin
                  used[s_q] <= 1'b0;
                end
              end
            end
          end
          default: begin
            if (tick_ok) begin
              blk_head <= (32'(blk_head) == SLOT_COUNT - 1) ? '0 : blk_head + 1'b1;
              blk_cnt  <= blk_cnt - 1'b1;
              if (push_ok) begin
                cnt[0] <= cnt[0] + 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  // ready queue store, one ring of slot entries per level
  mfq_ram #(.WIDTH(HW), .DEPTH(RQD)) u_rq_ram (
    .clk   (clk),
    .we    (rq_we),
    .waddr (rq_waddr),
    .wdata (in_q.op == OP_ADMIT ? free_s : s_q),
    .re    (rq_re),
    .raddr (rq_raddr),
    .rdata (rq_rdata)
  );

  // blocked queue store
  mfq_ram #(.WIDTH(HW), .DEPTH(SLOT_COUNT)) u_bq_ram (
    .clk   (clk),
    .we    (bq_we),
    .waddr (bq_waddr),
    .wdata (s_q),
    .re    (cmd.read_a),
    .raddr (blk_head),
    .rdata (bq_rdata)
  );

  // process id per slot
  mfq_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT)) u_pid_ram (
    .clk   (clk),
    .we    (pid_we),
    .waddr (free_s),
    .wdata (in_q.proc_id),
    .re    (cmd.read_b),
    .raddr (s_b),
    .rdata (pid_rdata)
  );

  // wake time per slot
  mfq_ram #(.WIDTH(TW), .DEPTH(SLOT_COUNT)) u_wk_ram (
    .clk   (clk),
    .we    (wk_we),
    .waddr (s_q),
    .wdata (wk_wdata),
    .re    (cmd.read_b),
    .raddr (s_b),
    .rdata (wk_rdata)
  );

endmodule

[verif/multilevel_feedback_queue_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_tb
// Drives admit, dispatch, run outcome and tick words into the scheduler and
// checks every result word against a cycle-free model of the slot table,
// the four ready queues and the blocked queue. Runs several quantum settings
// and idling phases, with one long receiver stall.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_tb;
  import mfq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int NLVL = 4;
  localparam int WATCHDOG = 20000;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [QW-1:0] cfg_data = '0;

  multilevel_feedback_queue_scheduler uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // scheduler model state
  logic [QW-1:0] quanta [NLVL];
  logic [NSLOT-1:0] used_slots;
  logic [7:0] pid_of [NSLOT];
  logic [TW-1:0] wake_at [NSLOT];
  logic [3:0] level_q [NLVL][$];
  logic [3:0] blocked_q [$];
  logic [1:0] disp_level;
  logic disp_open;

  out_t expected_words [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  logic [TW-1:0] clock_ns = '0;

  function automatic out_t sched_predict(in_t w);
    out_t r;
    logic [TW:0] sum;
    logic [1:0] nl;
    int s;
    int l;
    r = '0;
    case (w.op)
      OP_ADMIT: begin
        s = -1;
        for (int i = NSLOT - 1; i >= 0; i--) if (!used_slots[i]) s = i;
        if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          used_slots[s] = 1'b1;
          pid_of[s] = w.proc_id;
          level_q[0].push_back(s[3:0]);
          r.slot = s[3:0];
          r.out_proc_id = w.proc_id;
        end
      end
      OP_DISPATCH: begin
        l = -1;
        for (int i = NLVL - 1; i >= 0; i--) if (level_q[i].size() != 0) l = i;
        if (l < 0) begin
          r.status = ST_IDLE;
        end else begin
          disp_level = l[1:0];
          disp_open = 1'b1;
          r.slot = level_q[l][0];
          r.out_proc_id = pid_of[r.slot];
          r.level = l[1:0];
          r.granted_quantum = quanta[l];
        end
      end
      OP_OUTCOME: begin
        if (!disp_open || level_q[disp_level].size() == 0) begin
          r.status = ST_NO_DISP;
        end else if (w.outcome == OC_NONE) begin
          r.status = ST_IDLE;
        end else begin
          r.slot = level_q[disp_level].pop_front();
          r.out_proc_id = pid_of[r.slot];
          r.level = disp_level;
          disp_open = 1'b0;
          if (w.outcome == OC_READY) begin
            nl = disp_level;
            if (w.burst >= quanta[disp_level] && nl != NLVL - 1) nl++;
            level_q[nl].push_back(r.slot);
            r.level = nl;
          end else if (w.outcome == OC_BLOCKED) begin
            sum = {1'b0, w.now} + w.io_wait + w.burst;
            wake_at[r.slot] = sum[TW] ? TMAX : sum[TW-1:0];
            blocked_q.push_back(r.slot);
          end else begin
            used_slots[r.slot] = 1'b0;
          end
        end
      end
      default: begin
        if (blocked_q.size() == 0 || wake_at[blocked_q[0]] > w.now) begin
          r.status = ST_IDLE;
        end else begin
          r.slot = blocked_q.pop_front();
          r.out_proc_id = pid_of[r.slot];
          level_q[0].push_back(r.slot);
        end
      end
    endcase
    return r;
  endfunction

  task automatic sched_clear();
    used_slots = '0;
    foreach (level_q[i]) level_q[i].delete();
    blocked_q.delete();
    disp_level = '0;
    disp_open = 1'b0;
    quanta[0] = QUANTUM0_RST;
    quanta[1] = QUANTUM1_RST;
    quanta[2] = QUANTUM2_RST;
    quanta[3] = QUANTUM3_RST;
  endtask

  // send one word, honoring the sender idle percentage; valid stays up after
  // the accept until the next word or an idle cycle replaces it
  task automatic send_word(in_t w, out_t typed, bit has_typed);
    out_t exp_w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    exp_w = sched_predict(w);
    if (has_typed && exp_w != typed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with model: row %h model %h", typed, exp_w);
    end
    expected_words.push_back(exp_w);
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // drive one quantum write; the caller drops the write enable afterwards
  task automatic write_quantum(logic [1:0] idx, logic [QW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    quanta[idx] = val;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_t rand_word(int mode);
    in_t w;
    w.proc_id = 8'($urandom);
    w.outcome = $urandom_range(99) < 90 ? 2'($urandom_range(2)) : OC_NONE;
    w.burst = $urandom_range(99) < 10 ? {QW{1'b1}} : QW'($urandom_range(80000));
    w.io_wait = $urandom_range(99) < 10 ? {QW{1'b1}} : QW'($urandom_range(50000));
    clock_ns = clock_ns + TW'($urandom_range(30000));
    w.now = $urandom_range(99) < 4 ? TMAX - TW'($urandom_range(3)) : clock_ns;
    if (mode == 0) w.op = 2'($urandom);
    else w.op = $urandom_range(99) < 15 ? OP_ADMIT :
                $urandom_range(99) < 50 ? OP_DISPATCH : OP_TICK;
    return w;
  endfunction

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each accepted result word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        if (out_data != expected_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", expected_words[0], out_data);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  typedef struct {
    in_t w;
    out_t typed;
    bit has_typed;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    in_t w;
    sched_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    w = '0; w.op = OP_DISPATCH;
    rows.push_back('{w, out_t'{ST_IDLE, 4'd0, 8'd0, 2'd0, '0}, 1});
    w.op = OP_OUTCOME;
    rows.push_back('{w, out_t'{ST_NO_DISP, 4'd0, 8'd0, 2'd0, '0}, 1});
    w.op = OP_TICK;
    rows.push_back('{w, out_t'{ST_IDLE, 4'd0, 8'd0, 2'd0, '0}, 1});
    w.op = OP_ADMIT; w.proc_id = 8'hFF;
    rows.push_back('{w, out_t'{ST_DONE, 4'd0, 8'hFF, 2'd0, '0}, 1});
    w.proc_id = 8'h00;
    rows.push_back('{w, out_t'{ST_DONE, 4'd1, 8'h00, 2'd0, '0}, 1});
    w.op = OP_DISPATCH;
    rows.push_back('{w, out_t'{ST_DONE, 4'd0, 8'hFF, 2'd0, QUANTUM0_RST}, 1});
    w.op = OP_DISPATCH;
    rows.push_back('{w, '0, 0});
    w.op = OP_OUTCOME; w.outcome = OC_NONE;
    rows.push_back('{w, out_t'{ST_IDLE, 4'd0, 8'd0, 2'd0, '0}, 1});
    w.outcome = OC_READY; w.burst = {QW{1'b1}};
    rows.push_back('{w, '0, 0});
    w.op = OP_DISPATCH; rows.push_back('{w, '0, 0});
    w.op = OP_OUTCOME; w.outcome = OC_BLOCKED; w.now = TMAX;
    w.io_wait = {QW{1'b1}};
    rows.push_back('{w, '0, 0});
    w.op = OP_TICK; w.now = TMAX - 1; rows.push_back('{w, '0, 0});
    w.now = TMAX; rows.push_back('{w, '0, 0});
    for (int k = 0; k < 8; k++) begin
      w.op = OP_DISPATCH; rows.push_back('{w, '0, 0});
      w.op = OP_OUTCOME; w.outcome = OC_READY; rows.push_back('{w, '0, 0});
    end
    w.op = OP_DISPATCH; rows.push_back('{w, '0, 0});
    w.op = OP_OUTCOME; w.outcome = OC_EXITED; rows.push_back('{w, '0, 0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].has_typed);
    drain();

    // fill the table to see the full status
    for (int k = 0; k < 17; k++) begin
      w = '0; w.op = OP_ADMIT; w.proc_id = 8'($urandom);
      send_word(w, '0, 0);
    end
    drain();

    // random phases with quantum settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_off = 300; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int q = 0; q < NLVL; q++)
        write_quantum(q[1:0], ph == 1 ? '0 : ph == 2 ? 30'd999999999 :
                      ph == 0 ? QW'($urandom_range(60000)) : QW'($urandom_range(80000)));
      cfg_we <= 1'b0;
      for (int k = 0; k < 70; k++) begin
        w = rand_word(($urandom_range(99) < 80) ? 1 : 0);
        if ($urandom_range(99) < 70 && w.op == OP_TICK) w.op = OP_OUTCOME;
        send_word(w, '0, 0);
      end
      drain();
    end

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/mfq_pkg.sv
src/mfq_ram.sv
src/mfq_ctrl.sv
src/mfq_dp.sv
src/multilevel_feedback_queue_scheduler.sv
verif/multilevel_feedback_queue_scheduler_tb.sv
